### hdl/timestamp_to_calendar_defines.svh
// Assertion macros shared by the timestamp_to_calendar RTL.
`ifndef TIMESTAMP_TO_CALENDAR_DEFINES_SVH
`define TIMESTAMP_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define TTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define TTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ttc_pkg.sv
// Types, constants and tables shared by the timestamp-to-calendar block.
`default_nettype none

package ttc_pkg;

  localparam int DIVIDEND_W = 64;
  localparam int REM_W      = 10;   // every divisor is below 1024

  // Divisor select codes for the shared divider
  typedef logic [1:0] divsel_t;
  localparam divsel_t DIV_1000 = 2'd0;
  localparam divsel_t DIV_60   = 2'd1;
  localparam divsel_t DIV_24   = 2'd2;
  localparam divsel_t DIV_7    = 2'd3;

  // Request from the sequencer to the divider
  typedef struct packed {
    logic    start;
    divsel_t sel;
  } div_req_t;

  // Calendar constants
  localparam logic [11:0] BASE_YEAR     = 12'd1700;
  localparam logic [6:0]  C100_LAST     = 7'd99;
  localparam logic [8:0]  C400_LAST     = 9'd399;
  localparam logic [8:0]  C400_INIT     = 9'd100;  // 1700 mod 400
  localparam logic [8:0]  YEAR_LEN      = 9'd365;
  localparam logic [8:0]  YEAR_LEN_LEAP = 9'd366;
  localparam logic [3:0]  MONTH_FEB     = 4'd1;
  localparam logic [3:0]  MONTH_DEC     = 4'd11;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [REM_W-1:0] div_value(input divsel_t sel);
    logic [REM_W-1:0] v;
    unique case (sel)
      DIV_1000: v = 10'd1000;
      DIV_60:   v = 10'd60;
      DIV_24:   v = 10'd24;
      DIV_7:    v = 10'd7;
      default:  v = 10'd7;
    endcase
    return v;
  endfunction

  // Days in month idx (0 is January), February stretched in leap years
  function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
    logic [4:0] d;
    d = MONTH_LEN[idx];
    if (idx == MONTH_FEB && leap) begin
      d = 5'd29;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### hdl/ttc_div.sv
// Shared radix-16 restoring divider: 64-bit dividend by a small constant.
`default_nettype none

module ttc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ttc_pkg::div_req_t             req_i,
  input  logic [ttc_pkg::DIVIDEND_W-1:0] dividend_i,
  output logic [ttc_pkg::DIVIDEND_W-1:0] quotient_o,
  output logic [ttc_pkg::REM_W-1:0]      remainder_o,
  output logic                          done_o
);
  import ttc_pkg::*;

  localparam int STEPS  = 4;                    // quotient bits per cycle
  localparam int PASSES = DIVIDEND_W / STEPS;
  localparam int CNT_W  = $clog2(PASSES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PASSES - 1);

  logic [DIVIDEND_W-1:0] acc_r, acc_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [REM_W-1:0]      dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  run_r;
  logic                  done_r;

  // Four shift/compare/subtract steps; quotient bits shift into acc
  always_comb begin
    logic [REM_W:0] trial;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial   = {rem_nxt, acc_nxt[DIVIDEND_W-1]};
      acc_nxt = {acc_nxt[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        trial      = trial - {1'b0, dvs_r};
        acc_nxt[0] = 1'b1;
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == CNT_LAST);
      if (req_i.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      acc_r <= dividend_i;
      rem_r <= '0;
      dvs_r <= div_value(req_i.sel);
    end else if (run_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient_o  = acc_r;
  assign remainder_o = rem_r;
  assign done_o      = done_r;

endmodule

`default_nettype wire

### hdl/timestamp_to_calendar.sv
// Top level: sequencer turning a nanosecond timestamp into calendar fields.
//
// Usage: drive in_timestamp (ns since 1700-01-01 00:00:00) and pulse start
// while busy is low; the word is taken at that clock edge. busy then stays
// high until the result has been shown. The result fields appear on the out_
// ports for exactly one cycle with out_valid high; the receiver cannot stall,
// so it must capture them in that cycle.
// Sequence: eight constant divisions on one shared divider, 1000, 1000,
// 1000, 60, 60 and 24, then 7 for the weekday; a walk of one whole year
// per step past 1700 (up to 584); 7 for the week number; a walk of one
// whole month per step (up to 11); then the output. One word is in flight
// at a time; the next can be accepted in the cycle after the result.
// Reset (rst_n low, synchronous) returns the sequencer and divider to idle;
// no word is in progress and no result is pending afterwards.
`default_nettype none
`include "timestamp_to_calendar_defines.svh"

module timestamp_to_calendar (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_timestamp,
  output logic        out_valid,
  output logic [9:0]  out_nanosecond,
  output logic [9:0]  out_microsecond,
  output logic [9:0]  out_millisecond,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [2:0]  out_weekday,
  output logic [11:0] out_calendar_year,
  output logic [5:0]  out_week_number,
  output logic [8:0]  out_year_day,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month
);
  import ttc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_YEAR  = 3'd2;
  localparam logic [2:0] S_MONTH = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Division steps
  localparam logic [2:0] STEP_NS   = 3'd0;
  localparam logic [2:0] STEP_US   = 3'd1;
  localparam logic [2:0] STEP_MS   = 3'd2;
  localparam logic [2:0] STEP_SEC  = 3'd3;
  localparam logic [2:0] STEP_MIN  = 3'd4;
  localparam logic [2:0] STEP_HR   = 3'd5;
  localparam logic [2:0] STEP_WD   = 3'd6;
  localparam logic [2:0] STEP_WEEK = 3'd7;

  localparam int DAYS_W = 18;  // whole days fit below 2^18 for any input

  function automatic divsel_t step_sel(input logic [2:0] s);
    divsel_t v;
    case (s) inside
      STEP_NS, STEP_US, STEP_MS: v = DIV_1000;
      STEP_SEC, STEP_MIN:        v = DIV_60;
      STEP_HR:                   v = DIV_24;
      default:                   v = DIV_7;
    endcase
    return v;
  endfunction

  logic [2:0]        state_r;
  logic [2:0]        step_r;
  logic [9:0]        ns_r, us_r, ms_r;
  logic [5:0]        sec_r, min_r;
  logic [4:0]        hr_r;
  logic [2:0]        wd_r;
  logic [5:0]        week_r;
  logic [8:0]        yday_r;
  logic [DAYS_W-1:0] days_r;
  logic [11:0]       year_r;
  logic [1:0]        c4_r;
  logic [6:0]        c100_r;
  logic [8:0]        c400_r;
  logic [3:0]        month_r;

  div_req_t          div_req;
  logic [2:0]        issue_step;
  logic [63:0]       dividend;
  logic [63:0]       quot;
  logic [REM_W-1:0]  rem;
  logic              div_done;

  logic              leap;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              year_fits;
  logic              month_fits;
  logic              walk_ok;

  ttc_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_i       (div_req),
    .dividend_i  (dividend),
    .quotient_o  (quot),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  // Leap rule from running mod-4/100/400 counters
  assign leap       = (c4_r == 2'd0) && ((c100_r != 7'd0) || (c400_r == 9'd0));
  assign ylen       = leap ? YEAR_LEN_LEAP : YEAR_LEN;
  assign year_fits  = days_r >= {{(DAYS_W-9){1'b0}}, ylen};
  assign mlen       = month_days(month_r, leap);
  assign month_fits = (month_r < MONTH_DEC) && (days_r[8:0] >= {4'd0, mlen});

  // Divider requests
  always_comb begin
    issue_step    = 3'(step_r + 3'd1);
    dividend      = quot;
    div_req.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        issue_step    = STEP_NS;
        dividend      = in_timestamp;
        div_req.start = start;
      end
      S_DIV: begin
        if (step_r == STEP_HR) begin
          dividend = quot + 64'd4;  // 1700-01-01 was a Friday
        end
        div_req.start = div_done && (step_r != STEP_WD) && (step_r != STEP_WEEK);
      end
      S_YEAR: begin
        issue_step    = STEP_WEEK;
        dividend      = {55'd0, days_r[8:0]};
        div_req.start = !year_fits;
      end
      default: begin
      end
    endcase
    div_req.sel = step_sel(issue_step);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_NS;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DIV;
            step_r  <= STEP_NS;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (step_r == STEP_WD) begin
              state_r <= S_YEAR;
            end else if (step_r == STEP_WEEK) begin
              state_r <= S_MONTH;
            end else begin
              step_r <= issue_step;
            end
          end
        end
        S_YEAR: begin
          if (!year_fits) begin
            step_r  <= STEP_WEEK;
            state_r <= S_DIV;
          end
        end
        S_MONTH: begin
          if (!month_fits) begin
            state_r <= S_OUT;
          end
        end
        S_OUT:   state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Field datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      year_r  <= BASE_YEAR;
      c4_r    <= 2'd0;
      c100_r  <= 7'd0;
      c400_r  <= C400_INIT;
      month_r <= 4'd0;
    end
    // Capture each division's result
    if (state_r == S_DIV && div_done) begin
      unique case (step_r)
        STEP_NS:   ns_r   <= rem;
        STEP_US:   us_r   <= rem;
        STEP_MS:   ms_r   <= rem;
        STEP_SEC:  sec_r  <= rem[5:0];
        STEP_MIN:  min_r  <= rem[5:0];
        STEP_HR: begin
          hr_r   <= rem[4:0];
          days_r <= quot[DAYS_W-1:0];
        end
        STEP_WD:   wd_r   <= 3'(rem[2:0] + 3'd1);
        STEP_WEEK: week_r <= 6'(quot[5:0] + 6'd1);
        default: begin
        end
      endcase
    end
    // Walk whole years
    if (state_r == S_YEAR) begin
      if (year_fits) begin
        days_r <= days_r - {{(DAYS_W-9){1'b0}}, ylen};
        year_r <= year_r + 12'd1;
        c4_r   <= c4_r + 2'd1;
        c100_r <= (c100_r == C100_LAST) ? 7'd0 : c100_r + 7'd1;
        c400_r <= (c400_r == C400_LAST) ? 9'd0 : c400_r + 9'd1;
      end else begin
        yday_r <= days_r[8:0];
      end
    end
    // Walk whole months
    if (state_r == S_MONTH && month_fits) begin
      days_r  <= days_r - {{(DAYS_W-5){1'b0}}, mlen};
      month_r <= month_r + 4'd1;
    end
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_OUT);
  assign out_nanosecond       = ns_r;
  assign out_microsecond      = us_r;
  assign out_millisecond      = ms_r;
  assign out_second_of_minute = sec_r;
  assign out_minute_of_hour   = min_r;
  assign out_hour_of_day      = hr_r;
  assign out_weekday          = wd_r;
  assign out_calendar_year    = year_r;
  assign out_week_number      = week_r;
  assign out_year_day         = 9'(yday_r + 9'd1);
  assign out_month_number     = 4'(month_r + 4'd1);
  assign out_day_of_month     = 5'(days_r[4:0] + 5'd1);

  // Month walk ends no later than December with fewer than 31 days left
  assign walk_ok = (month_r <= MONTH_DEC) && (days_r < 18'd31);

  // Checks
  `TTC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `TTC_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid && !busy, "result strobe not single")
  `TTC_ASSERT_NOW(a_done_in_div, div_done, state_r == S_DIV, "divider done outside divide phase")
  `TTC_ASSERT_NOW(a_month_range, out_valid, walk_ok, "month walk overran")
  `TTC_ASSERT_NOW(a_year_left, state_r == S_MONTH, !year_fits, "year walk left a full year")

endmodule

`default_nettype wire
